// ===== rtl/strided_slice_grad_scatter_defines.svh =====
// Assertion macros used by the strided slice gradient scatter port checker.
`ifndef STRIDED_SLICE_GRAD_SCATTER_DEFINES_SVH
`define STRIDED_SLICE_GRAD_SCATTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SSG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssg_pkg.sv =====
// Shared types, constants and field helpers for the strided slice gradient scatter.
package ssg_pkg;

   localparam int MAX_DIMS          = 8;
   localparam int DEFAULT_DIMS      = 4;
   localparam int DEFAULT_DATA_BITS = 32;

   localparam int SHAPE_W     = 12;
   localparam int COORD_W     = 13;
   localparam int NORM_W      = COORD_W + 2;
   localparam int ADDR_W      = 48;
   localparam int VALUE_W     = 32;
   localparam int CSR_DATA_W  = 52;
   localparam int CSR_INDEX_W = 3;
   localparam int FIELD_EXT_W = MAX_DIMS * COORD_W;
   localparam int STEP_W      = $clog2(COORD_W);

   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_MODE      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE_ALL       = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_BEGIN_ALL       = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_END_OR_SIZE_ALL = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_ALL      = CSR_INDEX_W'(4);

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   typedef struct packed {
      logic ready;
      logic error;
      logic empty;
   } setup_status_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  out_address;
      logic [VALUE_W-1:0] out_value;
      logic               last;
      logic               config_error;
   } rsp_type;

   // Write to a defined register.
   function automatic logic csr_hit(input csr_write_type wr);
      return wr.en && (wr.index <= CSR_STRIDE_ALL);
   endfunction

   // Dimension 0 sits in the highest bits; fields past the register read as zero.
   function automatic logic [SHAPE_W-1:0] shape_field(input logic [ADDR_W-1:0] packed_val,
                                                     input int dims, input int dim);
      logic [FIELD_EXT_W-1:0] ext;
      ext = FIELD_EXT_W'(packed_val) >> ((dims - 1 - dim) * SHAPE_W);
      return ext[SHAPE_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] coord_field(input logic [CSR_DATA_W-1:0] packed_val,
                                                     input int dims, input int dim);
      logic [FIELD_EXT_W-1:0] ext;
      ext = FIELD_EXT_W'(packed_val) >> ((dims - 1 - dim) * COORD_W);
      return ext[COORD_W-1:0];
   endfunction

   function automatic logic signed [NORM_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
      return NORM_W'(signed'(v));
   endfunction

endpackage

// ===== rtl/ssg_setup.sv =====
// Register file and setup sequencer: normalized bounds, dimension weights and offsets.
module ssg_setup #(
   parameter int DIMS = ssg_pkg::DEFAULT_DIMS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssg_pkg::csr_write_type                 csr_write,
   output ssg_pkg::setup_status_type              status,
   output logic signed [ssg_pkg::COORD_W-1:0]     eff_begin  [DIMS],
   output logic signed [ssg_pkg::COORD_W-1:0]     eff_end    [DIMS],
   output logic signed [ssg_pkg::COORD_W-1:0]     eff_stride [DIMS],
   output logic        [ssg_pkg::ADDR_W-1:0]      begin_off  [DIMS],
   output logic        [ssg_pkg::ADDR_W-1:0]      step_off   [DIMS]
);
   import ssg_pkg::*;

   localparam int IDX_W = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIMS - 1);
   localparam logic signed [NORM_W-1:0] ZERO    = '0;
   localparam logic signed [NORM_W-1:0] ONE     = NORM_W'(1);
   localparam logic signed [NORM_W-1:0] NEG_ONE = NORM_W'(-1);

   typedef enum logic [2:0] {ST_WEIGHT, ST_REM, ST_NORM, ST_OFFS, ST_DONE} state_type;

   state_type               state_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [COORD_W-1:0]      rem_ff;
   logic [ADDR_W-1:0]       w_run_ff;
   logic                    error_ff;
   logic                    empty_ff;
   logic                    slice_mode_ff;
   logic [ADDR_W-1:0]       shape_all_ff;
   logic [CSR_DATA_W-1:0]   begin_all_ff;
   logic [CSR_DATA_W-1:0]   end_all_ff;
   logic [CSR_DATA_W-1:0]   stride_all_ff;
   logic [ADDR_W-1:0]       weight_ff     [DIMS];
   logic signed [COORD_W-1:0] eff_begin_ff  [DIMS];
   logic signed [COORD_W-1:0] eff_end_ff    [DIMS];
   logic signed [COORD_W-1:0] eff_stride_ff [DIMS];
   logic [ADDR_W-1:0]       begin_off_ff  [DIMS];
   logic [ADDR_W-1:0]       step_off_ff   [DIMS];

   logic [SHAPE_W-1:0]      shape_f  [DIMS];
   logic [COORD_W-1:0]      begin_f  [DIMS];
   logic [COORD_W-1:0]      end_f    [DIMS];
   logic [COORD_W-1:0]      stride_f [DIMS];
   logic [SHAPE_W-1:0]      sel_shape;
   logic [COORD_W-1:0]      sel_begin;
   logic [COORD_W-1:0]      sel_end;
   logic [COORD_W-1:0]      sel_stride;

   logic [COORD_W-1:0]      abs_end;
   logic [COORD_W-1:0]      rem_shift;
   logic [COORD_W-1:0]      rem_in;

   logic signed [NORM_W-1:0] size_n, b0, e0, s0, b_wrap, end_mod;
   logic signed [NORM_W-1:0] lo, hi, e_fix, e_wrap, e_sum;
   logic signed [NORM_W-1:0] norm_b, norm_e, norm_s;
   logic                     norm_empty;
   logic                     stride_zero;

   logic [ADDR_W+SHAPE_W-1:0]         weight_prod;
   logic [ADDR_W+COORD_W-1:0]         begin_prod;
   logic signed [ADDR_W+COORD_W:0]    step_prod;
   logic signed [COORD_W-1:0]         cur_stride;
   logic signed [ADDR_W:0]            cur_weight_s;

   function automatic logic signed [NORM_W-1:0] clamp_norm(input logic signed [NORM_W-1:0] v,
                                                          input logic signed [NORM_W-1:0] lo_v,
                                                          input logic signed [NORM_W-1:0] hi_v);
      if (v < lo_v) return lo_v;
      if (v > hi_v) return hi_v;
      return v;
   endfunction

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         shape_f[d]  = shape_field(shape_all_ff, DIMS, d);
         begin_f[d]  = coord_field(begin_all_ff, DIMS, d);
         end_f[d]    = coord_field(end_all_ff, DIMS, d);
         stride_f[d] = coord_field(stride_all_ff, DIMS, d);
      end
      sel_shape  = shape_f[idx_ff];
      sel_begin  = begin_f[idx_ff];
      sel_end    = end_f[idx_ff];
      sel_stride = stride_f[idx_ff];
   end

   // Restoring remainder of |end| by the dimension size, one bit per cycle.
   always_comb begin
      abs_end   = sel_end[COORD_W-1] ? COORD_W'(-sel_end) : sel_end;
      rem_shift = {rem_ff[COORD_W-2:0], abs_end[step_ff]};
      rem_in    = (rem_shift >= COORD_W'(sel_shape)) ? rem_shift - COORD_W'(sel_shape)
                                                     : rem_shift;
   end

   always_comb begin
      size_n  = signed'(NORM_W'(sel_shape));
      b0      = sext_coord(sel_begin);
      e0      = sext_coord(sel_end);
      s0      = sext_coord(sel_stride);
      b_wrap  = (b0 < ZERO) ? b0 + size_n : b0;
      end_mod = (size_n == ZERO || rem_ff == '0) ? ZERO : size_n - signed'(NORM_W'(rem_ff));
      lo      = (s0 < ZERO) ? NEG_ONE : ZERO;
      hi      = (s0 < ZERO) ? size_n - ONE : size_n;
      e_fix   = (e0 == ZERO && b0 < ZERO) ? size_n : e0;
      e_wrap  = (e_fix < ZERO) ? e_fix + size_n : e_fix;
      e_sum   = ZERO;
      if (slice_mode_ff) begin
         norm_b = clamp_norm(b_wrap, lo, hi);
         norm_e = clamp_norm(e_wrap, lo, hi);
         norm_s = s0;
      end else begin
         norm_b = clamp_norm(b_wrap, ZERO, size_n);
         e_sum  = norm_b + ((e0 < ZERO) ? end_mod : e0);
         norm_e = (e_sum > size_n) ? size_n : e_sum;
         norm_s = ONE;
      end
      norm_empty  = (norm_s > ZERO) ? (norm_b >= norm_e) : (norm_b <= norm_e);
      stride_zero = slice_mode_ff && (s0 == ZERO);
   end

   always_comb begin
      cur_stride   = eff_stride_ff[idx_ff];
      cur_weight_s = signed'({1'b0, weight_ff[idx_ff]});
      weight_prod  = w_run_ff * sel_shape;
      begin_prod   = weight_ff[idx_ff] * $unsigned(eff_begin_ff[idx_ff]);
      step_prod    = cur_stride * cur_weight_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WEIGHT;
         idx_ff        <= LAST_IDX;
         step_ff       <= '0;
         rem_ff        <= '0;
         w_run_ff      <= ADDR_W'(1);
         error_ff      <= 1'b0;
         empty_ff      <= 1'b0;
         slice_mode_ff <= 1'b0;
         shape_all_ff  <= '0;
         begin_all_ff  <= '0;
         end_all_ff    <= '0;
         stride_all_ff <= '0;
      end else if (csr_hit(csr_write)) begin
         case (csr_write.index)
            CSR_SLICE_MODE:      slice_mode_ff <= csr_write.data[0];
            CSR_SHAPE_ALL:       shape_all_ff  <= csr_write.data[ADDR_W-1:0];
            CSR_BEGIN_ALL:       begin_all_ff  <= csr_write.data;
            CSR_END_OR_SIZE_ALL: end_all_ff    <= csr_write.data;
            CSR_STRIDE_ALL:      stride_all_ff <= csr_write.data;
            default: ;
         endcase
         state_ff <= ST_WEIGHT;
         idx_ff   <= LAST_IDX;
         w_run_ff <= ADDR_W'(1);
         error_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_WEIGHT: begin
               // Innermost first: weight of a dimension is the product of inner sizes.
               weight_ff[idx_ff] <= w_run_ff;
               w_run_ff          <= weight_prod[ADDR_W-1:0];
               if (idx_ff == '0) begin
                  state_ff <= ST_REM;
                  step_ff  <= STEP_W'(COORD_W - 1);
                  rem_ff   <= '0;
               end else begin
                  idx_ff <= idx_ff - IDX_W'(1);
               end
            end
            ST_REM: begin
               rem_ff <= rem_in;
               if (step_ff == '0) begin
                  state_ff <= ST_NORM;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            ST_NORM: begin
               eff_begin_ff[idx_ff]  <= norm_b[COORD_W-1:0];
               eff_end_ff[idx_ff]    <= norm_e[COORD_W-1:0];
               eff_stride_ff[idx_ff] <= norm_s[COORD_W-1:0];
               error_ff              <= error_ff | stride_zero;
               empty_ff              <= empty_ff | norm_empty;
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_OFFS;
                  idx_ff   <= '0;
               end else begin
                  state_ff <= ST_REM;
                  idx_ff   <= idx_ff + IDX_W'(1);
                  step_ff  <= STEP_W'(COORD_W - 1);
                  rem_ff   <= '0;
               end
            end
            ST_OFFS: begin
               begin_off_ff[idx_ff] <= begin_prod[ADDR_W-1:0];
               step_off_ff[idx_ff]  <= step_prod[ADDR_W-1:0];
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            ST_DONE: ;
            default: state_ff <= ST_WEIGHT;
         endcase
      end
   end

   assign status.ready = (state_ff == ST_DONE);
   assign status.error = error_ff;
   assign status.empty = empty_ff;
   assign eff_begin    = eff_begin_ff;
   assign eff_end      = eff_end_ff;
   assign eff_stride   = eff_stride_ff;
   assign begin_off    = begin_off_ff;
   assign step_off     = step_off_ff;

endmodule

// ===== rtl/ssg_walk.sv =====
// Coordinate counter and address generator: one slice element per beat.
module ssg_walk #(
   parameter int DIMS      = ssg_pkg::DEFAULT_DIMS,
   parameter int DATA_BITS = ssg_pkg::DEFAULT_DATA_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                abort,
   input  logic                                accept,
   input  logic [ssg_pkg::VALUE_W-1:0]         grad_value,
   input  ssg_pkg::setup_status_type           status,
   input  logic signed [ssg_pkg::COORD_W-1:0]  eff_begin  [DIMS],
   input  logic signed [ssg_pkg::COORD_W-1:0]  eff_end    [DIMS],
   input  logic signed [ssg_pkg::COORD_W-1:0]  eff_stride [DIMS],
   input  logic        [ssg_pkg::ADDR_W-1:0]   begin_off  [DIMS],
   input  logic        [ssg_pkg::ADDR_W-1:0]   step_off   [DIMS],
   output logic                                result_valid,
   output ssg_pkg::rsp_type                    result
);
   import ssg_pkg::*;

   localparam logic [VALUE_W-1:0] DATA_MASK = VALUE_W'((65'd1 << DATA_BITS) - 65'd1);

   logic                      active_ff;
   logic signed [COORD_W-1:0] coord_ff [DIMS];
   logic [ADDR_W-1:0]         off_ff   [DIMS];

   logic signed [COORD_W-1:0] cur_coord  [DIMS];
   logic [ADDR_W-1:0]         cur_off    [DIMS];
   logic signed [NORM_W-1:0]  nxt        [DIMS];
   logic [DIMS-1:0]           past;
   logic [DIMS-1:0]           advance;
   logic [DIMS-1:0]           reload;
   logic signed [COORD_W-1:0] coord_in   [DIMS];
   logic [ADDR_W-1:0]         off_in     [DIMS];
   logic [ADDR_W-1:0]         addr;
   logic                      wrapped;
   logic                      start_err;
   logic                      drop;
   logic                      step_ok;

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         cur_coord[d] = active_ff ? coord_ff[d] : eff_begin[d];
         cur_off[d]   = active_ff ? off_ff[d] : begin_off[d];
         nxt[d]       = sext_coord(cur_coord[d]) + sext_coord(eff_stride[d]);
         past[d]      = eff_stride[d][COORD_W-1] ? (nxt[d] <= sext_coord(eff_end[d]))
                                                 : (nxt[d] >= sext_coord(eff_end[d]));
      end
      // Innermost dimension steps first; carry moves outward on wrap.
      wrapped = 1'b1;
      for (int d = DIMS - 1; d >= 0; d--) begin
         advance[d] = wrapped & ~past[d];
         reload[d]  = wrapped & past[d];
         wrapped    = wrapped & past[d];
      end
      addr = '0;
      for (int d = 0; d < DIMS; d++) begin
         addr = addr + cur_off[d];
      end
      for (int d = 0; d < DIMS; d++) begin
         if (advance[d]) begin
            coord_in[d] = nxt[d][COORD_W-1:0];
            off_in[d]   = cur_off[d] + step_off[d];
         end else if (reload[d]) begin
            coord_in[d] = eff_begin[d];
            off_in[d]   = begin_off[d];
         end else begin
            coord_in[d] = cur_coord[d];
            off_in[d]   = cur_off[d];
         end
      end
   end

   always_comb begin
      start_err    = !active_ff && status.error;
      drop         = !active_ff && !status.error && status.empty;
      step_ok      = accept && !start_err && !drop;
      result_valid = accept && !drop;
      if (start_err) begin
         result.out_address  = '0;
         result.out_value    = '0;
         result.last         = 1'b1;
         result.config_error = 1'b1;
      end else begin
         result.out_address  = addr;
         result.out_value    = grad_value & DATA_MASK;
         result.last         = wrapped;
         result.config_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (abort) begin
         active_ff <= 1'b0;
      end else if (step_ok) begin
         active_ff <= !wrapped;
         coord_ff  <= coord_in;
         off_ff    <= off_in;
      end
   end

endmodule

// ===== rtl/ssg_outbuf.sv =====
// Two-entry result buffer between the address generator and the response port.
module ssg_outbuf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssg_pkg::rsp_type push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output ssg_pkg::rsp_type out_data
);
   import ssg_pkg::*;

   localparam int DEPTH = 2;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type          entry_ff [DEPTH];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff           <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

endmodule

// ===== rtl/strided_slice_grad_scatter.sv =====
// Top level of the strided slice gradient scatter: registers, setup, walker, result buffer.
// Each result beat is registered in the two-entry result buffer before it is presented.
// Throughput: 1 beat per cycle while setup is done and the result buffer is not full.
// Setup: after reset and after each register write, req_ready is held low until setup is done.
// Reset: synchronous active high; clears registers to zero, no slice pass in flight.
module strided_slice_grad_scatter #(
   parameter int DIMS      = ssg_pkg::DEFAULT_DIMS,
   parameter int DATA_BITS = ssg_pkg::DEFAULT_DATA_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes
   input  logic                              csr_we,
   input  logic [ssg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Gradient element beats
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssg_pkg::VALUE_W-1:0]       req_grad_value,
   // Scatter beats
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssg_pkg::ADDR_W-1:0]        rsp_out_address,
   output logic [ssg_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                              rsp_last,
   output logic                              rsp_config_error
);
   import ssg_pkg::*;

   csr_write_type             csr_write;
   setup_status_type          status;
   logic                      cfg_hit;
   logic                      accept;
   logic                      buf_full;
   logic                      result_valid;
   rsp_type                   result;
   rsp_type                   rsp_data;

   logic signed [COORD_W-1:0] eff_begin  [DIMS];
   logic signed [COORD_W-1:0] eff_end    [DIMS];
   logic signed [COORD_W-1:0] eff_stride [DIMS];
   logic [ADDR_W-1:0]         begin_off  [DIMS];
   logic [ADDR_W-1:0]         step_off   [DIMS];

   assign csr_write = '{en: csr_we, index: csr_index, data: csr_wdata};
   // A write to a defined register ends any pass in progress and restarts setup.
   assign cfg_hit   = csr_hit(csr_write);

   // Input side stalls only during setup or when both buffer entries hold results.
   assign req_ready = status.ready && !buf_full;
   assign accept    = req_valid && req_ready;

   // Setup sequencer: per dimension it computes the weight (product of inner sizes),
   // wraps and clamps begin/end (slice-mode negative sizes via a bit-serial remainder),
   // flags a zero stride and an empty slice, and precomputes begin and step offsets.
   ssg_setup #(
      .DIMS (DIMS)
   ) u_setup (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .status     (status),
      .eff_begin  (eff_begin),
      .eff_end    (eff_end),
      .eff_stride (eff_stride),
      .begin_off  (begin_off),
      .step_off   (step_off)
   );

   // Walker: first beat of a pass starts from the begin corner; each beat sums the
   // per-dimension offsets into the address and steps the carry-chained counter.
   // Empty slices swallow the beat; a zero stride answers every beat with an error beat.
   ssg_walk #(
      .DIMS      (DIMS),
      .DATA_BITS (DATA_BITS)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .abort        (cfg_hit),
      .accept       (accept),
      .grad_value   (req_grad_value),
      .status       (status),
      .eff_begin    (eff_begin),
      .eff_end      (eff_end),
      .eff_stride   (eff_stride),
      .begin_off    (begin_off),
      .step_off     (step_off),
      .result_valid (result_valid),
      .result       (result)
   );

   // Two-entry buffer keeps the input flowing while a finished beat waits downstream.
   ssg_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_out_address  = rsp_data.out_address;
   assign rsp_out_value    = rsp_data.out_value;
   assign rsp_last         = rsp_data.last;
   assign rsp_config_error = rsp_data.config_error;

endmodule

// ===== rtl/ssg_checker.sv =====
// Port-level assertions for the strided slice gradient scatter, bound to the top level.
`include "strided_slice_grad_scatter_defines.svh"

module ssg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              csr_we,
   input logic [ssg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ssg_pkg::ADDR_W-1:0]        rsp_out_address,
   input logic [ssg_pkg::VALUE_W-1:0]       rsp_out_value,
   input logic                              rsp_last,
   input logic                              rsp_config_error
);
   import ssg_pkg::*;

   // A stalled result beat holds.
   `SSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_address) && $stable(rsp_out_value)
      && $stable(rsp_last) && $stable(rsp_config_error), "result beat changed while stalled")

   // Error beats carry nothing and close the pass.
   `SSG_ASSERT_IMPL(a_err_beat, clock, reset, rsp_valid && rsp_config_error,
      rsp_last && rsp_out_address == '0 && rsp_out_value == '0, "malformed error beat")

   // A register write restarts setup, so no beat is taken right after it.
   `SSG_ASSERT_NEXT(a_cfg_stall, clock, reset, csr_we && csr_index <= CSR_STRIDE_ALL,
      !req_ready, "input accepted during setup")

   // Results only appear after an accepted gradient beat.
   `SSG_ASSERT_IMPL(a_rsp_cause, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready), "result beat without an accepted input")

endmodule

bind strided_slice_grad_scatter ssg_checker u_checker (.*);

// ===== tb/ssg_scatter_checker.sv =====
// Scoreboard for the strided slice gradient scatter: predicts every scatter beat and compares.
module ssg_scatter_checker #(
   parameter int DIMS      = ssg_pkg::DEFAULT_DIMS,
   parameter int DATA_BITS = ssg_pkg::DEFAULT_DATA_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ssg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [ssg_pkg::VALUE_W-1:0]     req_grad_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [ssg_pkg::ADDR_W-1:0]      rsp_out_address,
   input  logic [ssg_pkg::VALUE_W-1:0]     rsp_out_value,
   input  logic                            rsp_last,
   input  logic                            rsp_config_error,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ssg_pkg::*;

   typedef enum logic [1:0] {WALK_RUN, WALK_EMPTY, WALK_BAD_STRIDE} walk_start_type;

   // register copies
   logic                  strided_q;
   logic [ADDR_W-1:0]     shape_q;
   logic [CSR_DATA_W-1:0] begin_q;
   logic [CSR_DATA_W-1:0] bound_q;
   logic [CSR_DATA_W-1:0] stride_q;

   // walk state, per dimension
   int                pos[DIMS];
   int                first[DIMS];
   int                bound[DIMS];
   int                step[DIMS];
   logic [ADDR_W-1:0] weight[DIMS];
   bit                walking = 1'b0;

   rsp_type expected_scatters[$];
   int      fails = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int dim_size(input int d);
      return int'(SHAPE_W'(shape_q >> ((DIMS - 1 - d) * SHAPE_W)));
   endfunction

   // 13-bit two's complement field; fields beyond the register read as zero
   function automatic int coord_of(input logic [CSR_DATA_W-1:0] r, input int d);
      logic [COORD_W-1:0] f;
      f = COORD_W'(r >> ((DIMS - 1 - d) * COORD_W));
      return int'(signed'(f));
   endfunction

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Normalize begin/end for a new pass; load the counter unless empty or a stride is zero.
   function automatic walk_start_type start_walk();
      logic [ADDR_W-1:0] w;
      int                sz, b, e, s, lo, hi;
      bit                empty;
      w = ADDR_W'(1);
      for (int d = DIMS - 1; d >= 0; d--) begin
         weight[d] = w;
         w = w * ADDR_W'(dim_size(d));
      end
      empty = 1'b0;
      for (int d = 0; d < DIMS; d++) begin
         sz = dim_size(d);
         b  = coord_of(begin_q, d);
         e  = coord_of(bound_q, d);
         s  = 1;
         if (strided_q) begin
            s = coord_of(stride_q, d);
            if (s == 0)
               return WALK_BAD_STRIDE;
            lo = (s < 0) ? -1 : 0;
            hi = (s < 0) ? sz - 1 : sz;
            if (e == 0 && b < 0)
               e += sz;
            if (e < 0)
               e += sz;
            if (b < 0)
               b += sz;
            e = clamp(e, lo, hi);
            b = clamp(b, lo, hi);
         end else begin
            if (b < 0)
               b += sz;
            b = clamp(b, 0, sz);
            if (e < 0)
               e = (sz == 0) ? 0 : ((e % sz) + sz) % sz;
            e = b + e;
            if (e > sz)
               e = sz;
         end
         first[d] = b;
         bound[d] = e;
         step[d]  = s;
         if ((s > 0) ? (b >= e) : (b <= e))
            empty = 1'b1;
      end
      if (empty)
         return WALK_EMPTY;
      for (int d = 0; d < DIMS; d++)
         pos[d] = first[d];
      return WALK_RUN;
   endfunction

   // Scatter beat caused by one gradient element; returns 0 when the element is dropped.
   function automatic bit scatter_for(input logic [VALUE_W-1:0] grad, output rsp_type r);
      walk_start_type    st;
      logic [ADDR_W-1:0] addr;
      logic [63:0]       keep;
      bit                carry;
      bit                past;
      int                nxt;
      r = '0;
      if (!walking) begin
         st = start_walk();
         if (st == WALK_BAD_STRIDE) begin
            r.last         = 1'b1;
            r.config_error = 1'b1;
            return 1'b1;
         end
         if (st == WALK_EMPTY)
            return 1'b0;
         walking = 1'b1;
      end
      addr = '0;
      for (int d = 0; d < DIMS; d++)
         addr += ADDR_W'({32'h0, 32'(pos[d])} * {16'h0, weight[d]});
      keep = (DATA_BITS >= 64) ? '1 : ((64'd1 << DATA_BITS) - 64'd1);
      r.out_address = addr;
      r.out_value   = VALUE_W'(64'(grad) & keep);
      // innermost dimension counts first, carries ripple outward
      carry = 1'b1;
      for (int d = DIMS - 1; d >= 0; d--) begin
         if (carry) begin
            nxt    = pos[d] + step[d];
            past   = (step[d] > 0) ? (nxt >= bound[d]) : (nxt <= bound[d]);
            pos[d] = past ? first[d] : nxt;
            carry  = past;
         end
      end
      if (carry)
         walking = 1'b0;
      r.last = carry;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         strided_q = 1'b0;
         shape_q   = '0;
         begin_q   = '0;
         bound_q   = '0;
         stride_q  = '0;
         walking   = 1'b0;
         expected_scatters.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scatters.size() == 0) begin
               $error("unexpected scatter beat: out_address %h", rsp_out_address);
               fails++;
            end else begin
               want = expected_scatters.pop_front();
               if (rsp_out_address !== want.out_address) begin
                  $error("out_address: expected %h, got %h", want.out_address, rsp_out_address);
                  fails++;
               end
               if (rsp_out_value !== want.out_value) begin
                  $error("out_value: expected %h, got %h", want.out_value, rsp_out_value);
                  fails++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  fails++;
               end
               if (rsp_config_error !== want.config_error) begin
                  $error("config_error: expected %b, got %b", want.config_error,
                         rsp_config_error);
                  fails++;
               end
            end
         end
         // any defined register write kills the pass in progress
         if (csr_we && csr_index <= CSR_STRIDE_ALL) begin
            case (csr_index)
               CSR_SLICE_MODE:      strided_q = csr_wdata[0];
               CSR_SHAPE_ALL:       shape_q   = csr_wdata[ADDR_W-1:0];
               CSR_BEGIN_ALL:       begin_q   = csr_wdata;
               CSR_END_OR_SIZE_ALL: bound_q   = csr_wdata;
               default:             stride_q  = csr_wdata;
            endcase
            walking = 1'b0;
         end
         if (req_valid && req_ready) begin
            if (scatter_for(req_grad_value, want))
               expected_scatters = {expected_scatters, want};
         end
      end
      fail_count <= fails;
      pending    <= expected_scatters.size();
   end

endmodule

// ===== tb/tb_strided_slice_grad_scatter.sv =====
// Testbench top for the strided slice gradient scatter: stimulus, handshakes and verdict.
module tb_strided_slice_grad_scatter;
   timeunit 1ns;
   timeprecision 1ps;
   import ssg_pkg::*;

   localparam int DIMS         = DEFAULT_DIMS;
   localparam int DATA_BITS    = DEFAULT_DATA_BITS;
   localparam int RANDOM_BEATS = 600;
   localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either channel
   localparam logic MODE_SLICE   = 1'b0;
   localparam logic MODE_STRIDED = 1'b1;
   // index past the register map; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = '1;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_we         = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;
   logic                   req_valid      = 1'b0;
   logic [VALUE_W-1:0]     req_grad_value = '0;
   logic                   rsp_ready      = 1'b0;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [ADDR_W-1:0]      rsp_out_address;
   logic [VALUE_W-1:0]     rsp_out_value;
   logic                   rsp_last;
   logic                   rsp_config_error;

   int fail_count;
   int pending;
   int sent         = 0;
   int quiet_cycles = 0;
   int ready_hold   = 0;
   bit steady       = 1'b0;   // set for phases with no gaps on either side

   strided_slice_grad_scatter DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_grad_value   (req_grad_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_address  (rsp_out_address),
      .rsp_out_value    (rsp_out_value),
      .rsp_last         (rsp_last),
      .rsp_config_error (rsp_config_error)
   );

   ssg_scatter_checker #(
      .DIMS      (DIMS),
      .DATA_BITS (DATA_BITS)
   ) u_scoreboard (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_grad_value   (req_grad_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_address  (rsp_out_address),
      .rsp_out_value    (rsp_out_value),
      .rsp_last         (rsp_last),
      .rsp_config_error (rsp_config_error),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always #10 clock = ~clock;

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Scatter side backpressure. A stall may outlive a steady phase's start; harmless.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                  : $urandom_range(10, 30);
      end
   end

   // Watchdog: a lost or stuck beat shows up as a long run with no handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Full register set, back to back with csr_we held high, then dropped.
   task automatic write_settings(input logic mode, input logic [ADDR_W-1:0] shape,
                                 input logic [CSR_DATA_W-1:0] beg,
                                 input logic [CSR_DATA_W-1:0] bnd,
                                 input logic [CSR_DATA_W-1:0] strd, input bit poke_unmapped);
      csr_we    <= 1'b1;
      csr_index <= CSR_SLICE_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_index <= CSR_SHAPE_ALL;
      csr_wdata <= CSR_DATA_W'(shape);
      @(posedge clock);
      csr_index <= CSR_BEGIN_ALL;
      csr_wdata <= beg;
      @(posedge clock);
      csr_index <= CSR_END_OR_SIZE_ALL;
      csr_wdata <= bnd;
      @(posedge clock);
      csr_index <= CSR_STRIDE_ALL;
      csr_wdata <= strd;
      @(posedge clock);
      if (poke_unmapped) begin
         csr_index <= CSR_UNMAPPED;
         csr_wdata <= CSR_DATA_W'({$urandom, $urandom});
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // One gradient beat; valid is lowered only when a gap precedes it.
   task automatic send_grad(input logic [VALUE_W-1:0] grad);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_grad_value <= grad;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Block idle: nothing outstanding, with extra waiting for a dropped beat still in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed small slices with random spellings of the same bounds;
   // some phases get one noisy dimension, a few are raw random registers.
   task automatic random_setting();
      logic                  mode;
      logic [ADDR_W-1:0]     shape;
      logic [CSR_DATA_W-1:0] beg, bnd, strd;
      int                    style, noisy, sz, b, e, s;
      mode  = 1'($urandom_range(0, 1));
      style = $urandom_range(0, 9);
      noisy = $urandom_range(0, DIMS - 1);
      shape = ADDR_W'({$urandom, $urandom});
      beg   = CSR_DATA_W'({$urandom, $urandom});
      bnd   = CSR_DATA_W'({$urandom, $urandom});
      strd  = CSR_DATA_W'({$urandom, $urandom});
      if (style < 8) begin
         for (int d = 0; d < DIMS; d++) begin
            sz = $urandom_range(1, 4);
            b  = $urandom_range(0, sz - 1);
            s  = 1;
            if (mode == MODE_SLICE) begin
               e = $urandom_range(1, sz - b);      // a size here
            end else begin
               s = $urandom_range(1, 3);
               if ($urandom_range(0, 1))
                  s = -s;
               if (s > 0) begin
                  e = $urandom_range(b + 1, sz);
               end else begin
                  e = int'($urandom_range(0, b)) - 1;
                  if (e == -1)
                     e = -sz - 1;                  // wraps to -1, the downward stop
               end
            end
            // negative spelling: wraps back to the same point
            if (b > 0 && $urandom_range(0, 2) == 0)
               b -= sz;
            if (e > 0 && e < sz && $urandom_range(0, 2) == 0)
               e -= sz;
            if (style >= 6 && d == noisy) begin
               sz = $urandom_range(0, 9);
               b  = int'($urandom_range(0, 20)) - 10;
               e  = int'($urandom_range(0, 20)) - 10;
               s  = int'($urandom_range(0, 8)) - 4;
            end
            shape[(DIMS-1-d)*SHAPE_W +: SHAPE_W] = SHAPE_W'(sz);
            beg[(DIMS-1-d)*COORD_W +: COORD_W]   = COORD_W'(b);
            bnd[(DIMS-1-d)*COORD_W +: COORD_W]   = COORD_W'(e);
            if (mode == MODE_STRIDED)
               strd[(DIMS-1-d)*COORD_W +: COORD_W] = COORD_W'(s);
         end
      end
      write_settings(mode, shape, beg, bnd, strd, $urandom_range(0, 7) == 0);
   endtask

   initial begin
      int beats;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: zero shape in slice mode, the beat is dropped.
      send_grad(32'h0000_0000);
      wait_idle();

      // Zero stride in strided mode: error beats, no pass starts.
      write_settings(MODE_STRIDED, {4{12'd2}}, '0, {4{13'd2}},
                     {13'd1, 13'd1, 13'd0, 13'd1}, 1'b0);
      send_grad(32'hffff_ffff);
      send_grad(32'h0000_0000);
      wait_idle();

      // Negative strides, wrapped begin/end, zero end with negative begin.
      // Six-beat pass; the seventh beat opens a new pass that the next write aborts.
      write_settings(MODE_STRIDED, {12'd2, 12'd3, 12'd2, 12'd4},
                     {13'(-1), 13'(2), 13'(1), 13'(-1)},
                     {13'(0), 13'(-4), 13'(2), 13'(-5)},
                     {13'(1), 13'(-1), 13'(1), 13'(-2)}, 1'b0);
      send_grad(32'h5555_5555);
      send_grad(32'haaaa_aaaa);
      repeat (5) send_grad($urandom);
      wait_idle();

      // Slice mode: wrapped begin, negative sizes taken modulo, size clipped to the
      // dimension, stride register ignored even though it holds zeros.
      write_settings(MODE_SLICE, {12'd3, 12'd2, 12'd4, 12'd1},
                     {13'(-2), 13'(0), 13'(1), 13'(0)},
                     {13'(-1), 13'(1), 13'(-3), 13'(5)}, '0, 1'b0);
      repeat (3) send_grad($urandom);
      wait_idle();

      // Extremes: all dimensions at maximum, most negative stride, address near the top.
      write_settings(MODE_STRIDED, '1, {4{13'h0fff}}, {4{13'h1000}}, {4{13'h1000}}, 1'b1);
      send_grad(32'hffff_ffff);
      send_grad(32'h0000_0000);
      wait_idle();

      // Zero-size dimension with negative sizes: empty, beat dropped.
      write_settings(MODE_SLICE, {12'd3, 12'd3, 12'd3, 12'd0}, {4{13'h1000}},
                     {4{13'h1fff}}, '0, 1'b0);
      send_grad($urandom);
      wait_idle();

      // Random phases until the beat budget is spent.
      beats = sent + RANDOM_BEATS;
      while (sent < beats) begin
         steady = ($urandom_range(0, 3) == 0);
         random_setting();
         repeat ($urandom_range(1, 40)) send_grad($urandom);
         wait_idle();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
